// ===== hw/rtl/trade_candle_aggregator_top_defines.svh =====
// assertion macros shared by the candle aggregator rtl
// expects clk and rst (synchronous, active high) in the including module
`ifndef TRADE_CANDLE_AGGREGATOR_TOP_DEFINES_SVH
`define TRADE_CANDLE_AGGREGATOR_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define TCA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tca check failed");

// next-cycle implication, off during reset
`define TCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tca check failed");

`endif

// ===== hw/rtl/tca_pkg.sv =====
// widths, constants and shared types of the candle aggregator
// no dependencies
package tca_pkg;

  localparam int PRICE_BITS  = 32;
  localparam int AMOUNT_BITS = 24;

  localparam int IN_PRICE_W  = 32;
  localparam int IN_AMOUNT_W = 24;
  localparam int TS_W        = 64;
  localparam int WIN_W       = 40;
  localparam int VOL_W       = 40;
  localparam int NOT_W       = 64;
  localparam int AVG_W       = 32;
  localparam int OUT_PRICE_W = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60000000);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int DCNT_W = $clog2(AVG_W + 1);

  // one finished candle
  typedef struct packed {
    logic [PRICE_BITS-1:0] open_p;
    logic [PRICE_BITS-1:0] close_p;
    logic [PRICE_BITS-1:0] low_p;
    logic [PRICE_BITS-1:0] high_p;
    logic [VOL_W-1:0]      buy_vol;
    logic [VOL_W-1:0]      sell_vol;
    logic [NOT_W-1:0]      buy_not;
    logic [NOT_W-1:0]      sell_not;
    logic [TS_W-1:0]       start;
    logic                  last;
  } cndl_t;

  // queue write: cnt entries, a first, then b
  typedef struct packed {
    logic [1:0] cnt;
    cndl_t      a;
    cndl_t      b;
  } qwr_t;

  typedef struct packed {
    logic             busy;
    logic [AVG_W-1:0] quot;
  } div_res_t;

endpackage

// ===== hw/rtl/tca_front.sv =====
// front end: trade register, candle accumulation, window decision
// depends on tca_pkg
module tca_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [tca_pkg::WIN_W-1:0]     cfg_wr_data,
  input  logic                          push,
  output logic                          full,
  input  logic [tca_pkg::TS_W-1:0]      timestamp_us,
  input  logic [tca_pkg::IN_PRICE_W-1:0] price,
  input  logic [tca_pkg::IN_AMOUNT_W-1:0] amount,
  input  logic                          is_buy,
  input  logic                          end_of_stream,
  input  logic [tca_pkg::QCNT_W-1:0]    q_free,
  output tca_pkg::qwr_t                 qwr
);
  import tca_pkg::*;

  localparam int PROD_W = PRICE_BITS + AMOUNT_BITS;

  logic [WIN_W-1:0] window;

  // trade stage
  logic                   a_valid;
  logic [TS_W-1:0]        a_ts;
  logic [PRICE_BITS-1:0]  a_p;
  logic [AMOUNT_BITS-1:0] a_amt;
  logic                   a_buy;
  logic                   a_eos;
  logic [NOT_W-1:0]       a_prod;

  // open candle
  logic                  active;
  logic [TS_W-1:0]       start_time;
  logic [PRICE_BITS-1:0] open_p, close_p, low_p, high_p;
  logic [VOL_W-1:0]      buy_vol, sell_vol;
  logic [NOT_W-1:0]      buy_not, sell_not;

  logic                   accept, go;
  logic [PRICE_BITS-1:0]  in_p;
  logic [AMOUNT_BITS-1:0] in_amt;
  logic [PROD_W-1:0]      prod_full;
  logic [127:0]           prod_x;
  logic [NOT_W-1:0]       prod_sat;

  logic [TS_W-1:0]       elapsed;
  logic                  expired, emit_old, opening;
  logic [PRICE_BITS-1:0] low_next, high_next, open_next;
  logic [TS_W-1:0]       start_next;
  logic [VOL_W-1:0]      vol_base, buy_vol_next, sell_vol_next, vol_sum;
  logic [NOT_W-1:0]      not_base, buy_not_next, sell_not_next, not_sum;
  logic [VOL_W:0]        vol_add;
  logic [NOT_W:0]        not_add;
  cndl_t                 old_c, new_c;

  assign in_p      = PRICE_BITS'(price);
  assign in_amt    = AMOUNT_BITS'(amount);
  assign prod_full = PROD_W'(in_p) * PROD_W'(in_amt);
  assign prod_x    = 128'(prod_full);
  assign prod_sat  = (|prod_x[127:NOT_W]) ? '1 : prod_x[NOT_W-1:0];

  // room for two candles keeps a split trade from overrunning the queue
  assign go     = (q_free >= QCNT_W'(2));
  assign full   = a_valid && !go;
  assign accept = push && !full;

  assign elapsed  = a_ts - start_time;
  assign expired  = (elapsed >= TS_W'(window));
  assign emit_old = active && expired;
  assign opening  = !active || expired;

  always_comb begin
    start_next = opening ? a_ts : start_time;
    open_next  = opening ? a_p : open_p;
    low_next   = (opening || (a_p < low_p)) ? a_p : low_p;
    high_next  = (opening || (a_p > high_p)) ? a_p : high_p;

    vol_base = opening ? '0 : (a_buy ? buy_vol : sell_vol);
    not_base = opening ? '0 : (a_buy ? buy_not : sell_not);
    vol_add  = {1'b0, vol_base} + (VOL_W + 1)'(a_amt);
    not_add  = {1'b0, not_base} + {1'b0, a_prod};
    vol_sum  = vol_add[VOL_W] ? '1 : vol_add[VOL_W-1:0];
    not_sum  = not_add[NOT_W] ? '1 : not_add[NOT_W-1:0];

    buy_vol_next  = a_buy ? vol_sum : (opening ? '0 : buy_vol);
    buy_not_next  = a_buy ? not_sum : (opening ? '0 : buy_not);
    sell_vol_next = a_buy ? (opening ? '0 : sell_vol) : vol_sum;
    sell_not_next = a_buy ? (opening ? '0 : sell_not) : not_sum;

    old_c.open_p   = open_p;
    old_c.close_p  = close_p;
    old_c.low_p    = low_p;
    old_c.high_p   = high_p;
    old_c.buy_vol  = buy_vol;
    old_c.sell_vol = sell_vol;
    old_c.buy_not  = buy_not;
    old_c.sell_not = sell_not;
    old_c.start    = start_time;
    old_c.last     = !a_eos;

    new_c.open_p   = open_next;
    new_c.close_p  = a_p;
    new_c.low_p    = low_next;
    new_c.high_p   = high_next;
    new_c.buy_vol  = buy_vol_next;
    new_c.sell_vol = sell_vol_next;
    new_c.buy_not  = buy_not_next;
    new_c.sell_not = sell_not_next;
    new_c.start    = start_next;
    new_c.last     = 1'b1;

    qwr.cnt = (a_valid && go) ? (2'(emit_old) + 2'(a_eos)) : 2'd0;
    qwr.a   = emit_old ? old_c : new_c;
    qwr.b   = new_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window  <= WINDOW_RESET;
      a_valid <= 1'b0;
      active  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window <= cfg_wr_data;
      end
      if (accept) begin
        a_valid <= 1'b1;
      end else if (go) begin
        a_valid <= 1'b0;
      end
      if (a_valid && go) begin
        active <= !a_eos;
      end
    end
    if (accept) begin
      a_ts   <= timestamp_us;
      a_p    <= in_p;
      a_amt  <= in_amt;
      a_buy  <= is_buy;
      a_eos  <= end_of_stream;
      a_prod <= prod_sat;
    end
    if (a_valid && go) begin
      start_time <= start_next;
      open_p     <= open_next;
      close_p    <= a_p;
      low_p      <= low_next;
      high_p     <= high_next;
      buy_vol    <= buy_vol_next;
      sell_vol   <= sell_vol_next;
      buy_not    <= buy_not_next;
      sell_not   <= sell_not_next;
    end
  end

endmodule

// ===== hw/rtl/tca_queue.sv =====
// small candle queue between front and back, up to two writes per cycle
// depends on tca_pkg and trade_candle_aggregator_top_defines.svh
`include "trade_candle_aggregator_top_defines.svh"

module tca_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  tca_pkg::qwr_t              qwr,
  output logic [tca_pkg::QCNT_W-1:0] free,
  output logic                       nonempty,
  output tca_pkg::cndl_t             head,
  input  logic                       rd_en
);
  import tca_pkg::*;

  cndl_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [1:0]        wr_cnt;

  assign wr_cnt   = qwr.cnt;
  assign free     = QCNT_W'(QDEPTH) - count;
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(wr_cnt);
      rd_ptr <= rd_ptr + QPTR_W'(rd_en);
      count  <= count + QCNT_W'(wr_cnt) - QCNT_W'(rd_en);
    end
    if (wr_cnt != 2'd0) begin
      mem[wr_ptr] <= qwr.a;
    end
    if (wr_cnt == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= qwr.b;
    end
  end

  `TCA_ASSERT_IMPL(a_cnt_range, 1'b1, count <= QCNT_W'(QDEPTH))
  `TCA_ASSERT_IMPL(a_pop_nonempty, rd_en, count != '0)
  `TCA_ASSERT_IMPL(a_push_room, 1'b1, QCNT_W'(wr_cnt) <= free)
  `TCA_ASSERT_IMPL(a_ptr_track, 1'b1, QPTR_W'(wr_ptr - rd_ptr) == count[QPTR_W-1:0])
  `TCA_ASSERT_NEXT(a_pop_only, rd_en && (wr_cnt == 2'd0), count == QCNT_W'($past(count) - 1'b1))

endmodule

// ===== hw/rtl/tca_div.sv =====
// radix-2 restoring divider: notional / volume, quotient saturated to AVG_W bits
// depends on tca_pkg
module tca_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tca_pkg::NOT_W-1:0] notional,
  input  logic [tca_pkg::VOL_W-1:0] volume,
  output tca_pkg::div_res_t         res
);
  import tca_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [VOL_W-1:0]  rem;
  logic [VOL_W-1:0]  vol;
  logic [AVG_W-1:0]  nlow;
  logic [AVG_W-1:0]  q;
  logic              zero_f, sat_f;

  logic [AVG_W-1:0]  n_hi;
  logic [VOL_W:0]    shifted, diff;
  logic              ge;

  // high half at or above the divisor means the quotient does not fit
  assign n_hi    = notional[NOT_W-1:AVG_W];
  assign shifted = {rem, nlow[AVG_W-1]};
  assign ge      = (shifted >= {1'b0, vol});
  assign diff    = shifted - {1'b0, vol};

  assign res.busy = busy;
  assign res.quot = zero_f ? '0 : (sat_f ? '1 : q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DCNT_W'(AVG_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      rem    <= VOL_W'(n_hi);
      nlow   <= notional[AVG_W-1:0];
      vol    <= volume;
      q      <= '0;
      zero_f <= (volume == '0);
      sat_f  <= (VOL_W'(n_hi) >= volume);
    end else if (busy) begin
      nlow <= {nlow[AVG_W-2:0], 1'b0};
      q    <= {q[AVG_W-2:0], ge};
      rem  <= ge ? diff[VOL_W-1:0] : shifted[VOL_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/tca_back.sv =====
// back end: takes candles from the queue, computes side averages, holds the result
// depends on tca_pkg and tca_div
module tca_back (
  input  logic                            clk,
  input  logic                            rst,
  input  tca_pkg::cndl_t                  head,
  input  logic                            q_nonempty,
  output logic                            q_pop,
  input  logic                            pop,
  output logic                            empty,
  output logic [tca_pkg::OUT_PRICE_W-1:0] open_price,
  output logic [tca_pkg::OUT_PRICE_W-1:0] close_price,
  output logic [tca_pkg::OUT_PRICE_W-1:0] low_price,
  output logic [tca_pkg::OUT_PRICE_W-1:0] high_price,
  output logic [tca_pkg::AVG_W-1:0]       avg_buy_price,
  output logic [tca_pkg::AVG_W-1:0]       avg_sell_price,
  output logic [tca_pkg::VOL_W-1:0]       buy_volume,
  output logic [tca_pkg::VOL_W-1:0]       sell_volume,
  output logic [tca_pkg::TS_W-1:0]        window_start_us,
  output logic                            last_of_run
);
  import tca_pkg::*;

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  state_t    state;
  cndl_t     job;
  logic      out_valid;
  div_res_t  buy_res, sell_res;
  logic      load;

  assign q_pop = (state == ST_IDLE) && q_nonempty;
  assign load  = (state == ST_DIV) && !buy_res.busy && !sell_res.busy &&
                 (!out_valid || pop);
  assign empty = !out_valid;

  tca_div u_div_buy (
    .clk      (clk),
    .rst      (rst),
    .start    (q_pop),
    .notional (head.buy_not),
    .volume   (head.buy_vol),
    .res      (buy_res)
  );

  tca_div u_div_sell (
    .clk      (clk),
    .rst      (rst),
    .start    (q_pop),
    .notional (head.sell_not),
    .volume   (head.sell_vol),
    .res      (sell_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_nonempty) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
    if (q_pop) begin
      job <= head;
    end
    if (load) begin
      open_price      <= OUT_PRICE_W'(job.open_p);
      close_price     <= OUT_PRICE_W'(job.close_p);
      low_price       <= OUT_PRICE_W'(job.low_p);
      high_price      <= OUT_PRICE_W'(job.high_p);
      avg_buy_price   <= buy_res.quot;
      avg_sell_price  <= sell_res.quot;
      buy_volume      <= job.buy_vol;
      sell_volume     <= job.sell_vol;
      window_start_us <= job.start;
      last_of_run     <= job.last;
    end
  end

endmodule

// ===== hw/rtl/trade_candle_aggregator_top.sv =====
// top level of the trade candle aggregator
// depends on tca_pkg, tca_front, tca_queue, tca_back (with tca_div)
//
// trades come in through a queue-like port: a transaction happens when push is
// high and full is low. finished candles leave the same way: while empty is low
// the oldest candle sits on the result ports and pop takes it.
// the user writes window_us through cfg_wr_en / cfg_wr_data only while idle;
// the block does not enforce it. front end: a trade register (the price times
// amount product is formed on the way in) and the candle accumulator, one trade
// per cycle. a trade that closes the window and also carries end_of_stream
// writes two candles at once. back end: a four-entry candle queue feeds two
// 32-step restoring dividers (buy and sell average, run side by side) and an
// output register, which a finished candle reaches through the trade register,
// the queue and the dividers. throughput: trades at one per cycle while the
// queue has two free entries; candles drain one by one, paced by the dividers.
// a receiver that holds off pop keeps the result in the output register, then
// the queue fills and full rises; nothing is dropped.
// reset: window_us back to 60000000, no open candle, queue and result empty.
module trade_candle_aggregator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tca_pkg::WIN_W-1:0]       cfg_wr_data,
  input  logic                            push,
  output logic                            full,
  input  logic [tca_pkg::TS_W-1:0]        timestamp_us,
  input  logic [tca_pkg::IN_PRICE_W-1:0]  price,
  input  logic [tca_pkg::IN_AMOUNT_W-1:0] amount,
  input  logic                            is_buy,
  input  logic                            end_of_stream,
  input  logic                            pop,
  output logic                            empty,
  output logic [tca_pkg::OUT_PRICE_W-1:0] open_price,
  output logic [tca_pkg::OUT_PRICE_W-1:0] close_price,
  output logic [tca_pkg::OUT_PRICE_W-1:0] low_price,
  output logic [tca_pkg::OUT_PRICE_W-1:0] high_price,
  output logic [tca_pkg::AVG_W-1:0]       avg_buy_price,
  output logic [tca_pkg::AVG_W-1:0]       avg_sell_price,
  output logic [tca_pkg::VOL_W-1:0]       buy_volume,
  output logic [tca_pkg::VOL_W-1:0]       sell_volume,
  output logic [tca_pkg::TS_W-1:0]        window_start_us,
  output logic                            last_of_run
);
  import tca_pkg::*;

  // front to queue
  qwr_t              qwr;
  logic [QCNT_W-1:0] q_free;
  // queue to back
  cndl_t             q_head;
  logic              q_nonempty;
  logic              q_pop;

  // accumulate trades, decide window ends
  tca_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .push          (push),
    .full          (full),
    .timestamp_us  (timestamp_us),
    .price         (price),
    .amount        (amount),
    .is_buy        (is_buy),
    .end_of_stream (end_of_stream),
    .q_free        (q_free),
    .qwr           (qwr)
  );

  // decouples the front (one trade per cycle while not full) from the slow divide
  tca_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .qwr      (qwr),
    .free     (q_free),
    .nonempty (q_nonempty),
    .head     (q_head),
    .rd_en    (q_pop)
  );

  // averages and result register
  tca_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (q_head),
    .q_nonempty      (q_nonempty),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .open_price      (open_price),
    .close_price     (close_price),
    .low_price       (low_price),
    .high_price      (high_price),
    .avg_buy_price   (avg_buy_price),
    .avg_sell_price  (avg_sell_price),
    .buy_volume      (buy_volume),
    .sell_volume     (sell_volume),
    .window_start_us (window_start_us),
    .last_of_run     (last_of_run)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for trade_candle_aggregator_top: directed trade table, then random phases
// depends on tca_pkg and the aggregator rtl; predicts every finished candle and checks each one
module tb_top;
  import tca_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 48;      // settle time after the last owed candle, before a window write or the end
  localparam int LONG_HOLD    = 400;     // receiver hold-off that fills the candle queue
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic BUY   = 1'b1;
  localparam logic SELL  = 1'b0;
  localparam logic FLUSH = 1'b1;         // end_of_stream set
  localparam logic KEEP  = 1'b0;

  localparam logic [WIN_W-1:0] WIN_MAX = '1;

  // one trade as driven on the input ports
  typedef struct packed {
    logic [TS_W-1:0]        ts;
    logic [IN_PRICE_W-1:0]  price;
    logic [IN_AMOUNT_W-1:0] amount;
    logic                   is_buy;
    logic                   eos;
  } trade_t;

  // one finished candle as seen on the result ports
  typedef struct packed {
    logic [OUT_PRICE_W-1:0] open_p, close_p, low_p, high_p;
    logic [AVG_W-1:0]       avg_buy, avg_sell;
    logic [VOL_W-1:0]       buy_vol, sell_vol;
    logic [TS_W-1:0]        start;
    logic                   last;
  } candle_t;

  localparam candle_t NO_CANDLE = '0;

  // running candle kept by the predictor
  typedef struct {
    logic                  active;
    logic [TS_W-1:0]       start;
    logic [PRICE_BITS-1:0] open_p, close_p, low_p, high_p;
    logic [VOL_W-1:0]      buy_vol, sell_vol;
    logic [NOT_W-1:0]      buy_not, sell_not;
  } candle_acc_t;

  // a row of the directed table; typed rows carry their candle written out by hand
  typedef struct {
    trade_t  trd;
    logic    typed;
    candle_t want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [WIN_W-1:0]       cfg_wr_data;
  logic                   push;
  logic                   full;
  logic [TS_W-1:0]        timestamp_us;
  logic [IN_PRICE_W-1:0]  price;
  logic [IN_AMOUNT_W-1:0] amount;
  logic                   is_buy;
  logic                   end_of_stream;
  logic                   pop;
  logic                   empty;
  logic [OUT_PRICE_W-1:0] open_price, close_price, low_price, high_price;
  logic [AVG_W-1:0]       avg_buy_price, avg_sell_price;
  logic [VOL_W-1:0]       buy_volume, sell_volume;
  logic [TS_W-1:0]        window_start_us;
  logic                   last_of_run;

  // predictor state and the candles still owed by the block
  candle_acc_t      acc = '{default: '0};
  logic [WIN_W-1:0] window_len = WINDOW_RESET;
  candle_t          candles_due[$];
  stim_row_t        directed_rows[$];

  // random stimulus walk
  logic [TS_W-1:0]       ts_now = '0;
  logic [IN_PRICE_W-1:0] price_base = 32'd100000;

  // idling control: percent chance of a trade gap, shared by both sides (quartered for pop gaps)
  int idle_pct      = 0;
  int hold_requests = 0;
  int holds_done    = 0;

  int fail_count      = 0;
  int trades_sent     = 0;
  int candles_checked = 0;
  int cycle_count     = 0;

  trade_candle_aggregator_top u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .push            (push),
    .full            (full),
    .timestamp_us    (timestamp_us),
    .price           (price),
    .amount          (amount),
    .is_buy          (is_buy),
    .end_of_stream   (end_of_stream),
    .pop             (pop),
    .empty           (empty),
    .open_price      (open_price),
    .close_price     (close_price),
    .low_price       (low_price),
    .high_price      (high_price),
    .avg_buy_price   (avg_buy_price),
    .avg_sell_price  (avg_sell_price),
    .buy_volume      (buy_volume),
    .sell_volume     (sell_volume),
    .window_start_us (window_start_us),
    .last_of_run     (last_of_run)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d candles still owed", cycle_count,
               candles_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // notional over volume, truncated, clipped to the output width, 0 with no volume
  function automatic logic [AVG_W-1:0] side_average(logic [NOT_W-1:0] notional,
                                                    logic [VOL_W-1:0] vol);
    logic [NOT_W-1:0] q;
    if (vol == '0) return '0;
    q = notional / NOT_W'(vol);
    if (q > NOT_W'({AVG_W{1'b1}})) return '1;
    return q[AVG_W-1:0];
  endfunction

  function automatic candle_t finished_candle(logic last);
    candle_t c;
    c.open_p   = OUT_PRICE_W'(acc.open_p);
    c.close_p  = OUT_PRICE_W'(acc.close_p);
    c.low_p    = OUT_PRICE_W'(acc.low_p);
    c.high_p   = OUT_PRICE_W'(acc.high_p);
    c.avg_buy  = side_average(acc.buy_not, acc.buy_vol);
    c.avg_sell = side_average(acc.sell_not, acc.sell_vol);
    c.buy_vol  = acc.buy_vol;
    c.sell_vol = acc.sell_vol;
    c.start    = acc.start;
    c.last     = last;
    return c;
  endfunction

  function automatic void start_candle(logic [TS_W-1:0] ts, logic [PRICE_BITS-1:0] p);
    acc = '{default: '0};
    acc.active  = 1'b1;
    acc.start   = ts;
    acc.open_p  = p;
    acc.close_p = p;
    acc.low_p   = p;
    acc.high_p  = p;
  endfunction

  // adds one accepted trade to the predicted candle and queues the candles it finishes
  function automatic void fold_trade(trade_t t);
    logic [PRICE_BITS-1:0]  p;
    logic [AMOUNT_BITS-1:0] amt;
    logic [2*NOT_W-1:0]     wide;
    logic [NOT_W-1:0]       product;
    logic [NOT_W:0]         nsum;
    logic [VOL_W:0]         vsum;
    p   = t.price[PRICE_BITS-1:0];
    amt = t.amount[AMOUNT_BITS-1:0];
    if (!acc.active) begin
      start_candle(t.ts, p);
    end else if (t.ts - acc.start >= TS_W'(window_len)) begin
      // window over (a timestamp behind the start wraps and lands here too)
      candles_due = {candles_due, finished_candle(!t.eos)};
      start_candle(t.ts, p);
    end
    acc.close_p = p;
    if (p < acc.low_p) acc.low_p = p;
    if (p > acc.high_p) acc.high_p = p;
    // product and sums saturate instead of wrapping
    wide    = (2*NOT_W)'(p) * (2*NOT_W)'(amt);
    product = (wide[2*NOT_W-1:NOT_W] != '0) ? '1 : wide[NOT_W-1:0];
    if (t.is_buy) begin
      nsum = {1'b0, acc.buy_not} + {1'b0, product};
      vsum = {1'b0, acc.buy_vol} + (VOL_W+1)'(amt);
      acc.buy_not = nsum[NOT_W] ? '1 : nsum[NOT_W-1:0];
      acc.buy_vol = vsum[VOL_W] ? '1 : vsum[VOL_W-1:0];
    end else begin
      nsum = {1'b0, acc.sell_not} + {1'b0, product};
      vsum = {1'b0, acc.sell_vol} + (VOL_W+1)'(amt);
      acc.sell_not = nsum[NOT_W] ? '1 : nsum[NOT_W-1:0];
      acc.sell_vol = vsum[VOL_W] ? '1 : vsum[VOL_W-1:0];
    end
    if (t.eos) begin
      candles_due = {candles_due, finished_candle(1'b1)};
      acc.active = 1'b0;
    end
  endfunction

  function automatic void add_row(logic [TS_W-1:0] ts, logic [IN_PRICE_W-1:0] p,
                                  logic [IN_AMOUNT_W-1:0] amt, logic side, logic eos,
                                  logic typed, candle_t want);
    stim_row_t r;
    r.trd   = '{ts: ts, price: p, amount: amt, is_buy: side, eos: eos};
    r.typed = typed;
    r.want  = want;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // compares the candle on the result ports with the oldest one owed
  task automatic check_candle();
    candle_t want;
    if (candles_due.size() == 0) begin
      $error("candle with no trade behind it: open_price %0h window_start_us %0h",
             open_price, window_start_us);
      fail_count++;
      return;
    end
    want = candles_due.pop_front();
    check_field("open_price", 64'(want.open_p), 64'(open_price));
    check_field("close_price", 64'(want.close_p), 64'(close_price));
    check_field("low_price", 64'(want.low_p), 64'(low_price));
    check_field("high_price", 64'(want.high_p), 64'(high_price));
    check_field("avg_buy_price", 64'(want.avg_buy), 64'(avg_buy_price));
    check_field("avg_sell_price", 64'(want.avg_sell), 64'(avg_sell_price));
    check_field("buy_volume", 64'(want.buy_vol), 64'(buy_volume));
    check_field("sell_volume", 64'(want.sell_vol), 64'(sell_volume));
    check_field("window_start_us", want.start, window_start_us);
    check_field("last_of_run", 64'(want.last), 64'(last_of_run));
    candles_checked++;
  endtask

  // offers one trade until a transaction happens; push stays high afterwards so
  // back-to-back trades go in one per cycle while full stays low
  task automatic offer_trade(trade_t t, logic typed, candle_t want);
    int   gap;
    logic taken;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      gap  = $urandom_range(1, 14);
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push          = 1'b1;
    timestamp_us  = t.ts;
    price         = t.price;
    amount        = t.amount;
    is_buy        = t.is_buy;
    end_of_stream = t.eos;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !full;
      @(negedge clk);
    end
    fold_trade(t);
    if (typed) begin
      // hand-written candle stands in for the predicted one
      void'(candles_due.pop_back());
      candles_due = {candles_due, want};
    end
    trades_sent++;
  endtask

  // sender waits for every owed candle, lets the pipeline settle, then writes window_us
  task automatic settle_then_write(logic [WIN_W-1:0] value);
    push = 1'b0;
    while (candles_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en  = 1'b0;
    window_len = value;
  endtask

  // random trade: mostly steps inside the window with prices near a drifting
  // base, some steps right at the window edge, some backward or wild timestamps
  task automatic make_trade(output trade_t t);
    logic [TS_W-1:0] span;
    int pick;
    span = TS_W'(window_len) / 4;
    pick = $urandom_range(0, 99);
    if (pick < 65)
      ts_now = ts_now + ((span == '0) ? '0 : rand64() % (span + 1));
    else if (pick < 82)
      ts_now = ts_now + TS_W'(window_len) + TS_W'($urandom_range(0, 2)) - 1;
    else if (pick < 94 && pick >= 88)
      ts_now = ts_now - TS_W'($urandom_range(1, 1000000));
    else if (pick >= 94)
      ts_now = rand64();
    t.ts = ts_now;

    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      price_base = price_base + 32'($urandom_range(0, 200)) - 32'd100;
      t.price    = price_base;
    end else if (pick < 85) t.price = $urandom;
    else if (pick < 90) t.price = '0;
    else if (pick < 95) t.price = '1;
    else begin
      price_base = $urandom;
      t.price    = price_base;
    end

    pick = $urandom_range(0, 99);
    if (pick < 70) t.amount = IN_AMOUNT_W'($urandom_range(1, 1000));
    else if (pick < 85) t.amount = IN_AMOUNT_W'($urandom);
    else if (pick < 92) t.amount = '0;
    else t.amount = '1;

    t.is_buy = 1'($urandom_range(0, 1));
    t.eos    = ($urandom_range(0, 11) == 0) ? FLUSH : KEEP;
  endtask

  // make_trade trades, or with heavy set one heavy candle: near-max prices and amounts,
  // almost all buys, flushed at the end, so the buy notional runs into saturation
  task automatic run_random(int count, logic heavy);
    trade_t t;
    for (int i = 0; i < count; i++) begin
      if (heavy) begin
        ts_now   = ts_now + TS_W'($urandom_range(0, 1000));
        t.ts     = ts_now;
        t.price  = $urandom_range(32'hF800_0000, 32'hFFFF_FFFF);
        t.amount = 24'hFFF000 | IN_AMOUNT_W'($urandom_range(0, 4095));
        t.is_buy = ($urandom_range(0, 99) < 97) ? BUY : SELL;
        t.eos    = (i == count - 1) ? FLUSH : KEEP;
      end else begin
        make_trade(t);
      end
      offer_trade(t, 1'b0, NO_CANDLE);
    end
  endtask

  // result side: random pop gaps, plus one long hold-off on request that lets
  // the candle queue fill up and push full
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        stall_left = LONG_HOLD;
        holds_done++;
      end else if (stall_left == 0 && idle_pct != 0 &&
                   $urandom_range(1, 400) <= idle_pct) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) check_candle();
      @(negedge clk);
    end
  end

  // trade side: reset, directed table, random phases over several window settings
  initial begin : trade_side
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    push          = 1'b0;
    timestamp_us  = '0;
    price         = '0;
    amount        = '0;
    is_buy        = 1'b0;
    end_of_stream = 1'b0;

    // directed table, window at its reset value of 60000000
    // lone flushed trade at max price and amount
    add_row(64'd0, 32'hFFFF_FFFF, 24'hFF_FFFF, BUY, FLUSH, 1'b1,
            {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'h0, 40'hFF_FFFF, 40'h0, 64'd0, 1'b1});
    // zero price, zero amount: no volume on either side, averages 0
    add_row(64'd10, 32'd0, 24'd0, SELL, FLUSH, 1'b1,
            {32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 40'd0, 40'd0, 64'd10, 1'b1});
    // one candle with a new low, a zero-amount new high and a full-size sell
    add_row(64'd100, 32'd1000, 24'd5, BUY, KEEP, 1'b0, NO_CANDLE);
    add_row(64'd200, 32'd900, 24'd3, SELL, KEEP, 1'b0, NO_CANDLE);
    add_row(64'd300, 32'd1200, 24'd0, BUY, KEEP, 1'b0, NO_CANDLE);
    add_row(64'd400, 32'd1100, 24'hFF_FFFF, SELL, KEEP, 1'b0, NO_CANDLE);
    // exactly one window later and flushed: two candles from one trade
    add_row(64'd60000100, 32'd50, 24'd1, BUY, FLUSH, 1'b0, NO_CANDLE);
    add_row(64'd60000200, 32'd70, 24'd2, BUY, KEEP, 1'b0, NO_CANDLE);
    // timestamp behind the candle start wraps and starts a new candle
    add_row(64'd5, 32'd80, 24'd1, SELL, KEEP, 1'b0, NO_CANDLE);
    add_row(64'd60000004, 32'd81, 24'd1, BUY, KEEP, 1'b0, NO_CANDLE);
    add_row(64'd60000005, 32'd82, 24'd1, SELL, KEEP, 1'b0, NO_CANDLE);
    // max timestamp
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 24'd1, BUY, KEEP, 1'b0, NO_CANDLE);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'd2, 24'd1, SELL, FLUSH, 1'b0, NO_CANDLE);
    add_row(64'd0, 32'd3, 24'd7, SELL, FLUSH, 1'b1,
            {32'd3, 32'd3, 32'd3, 32'd3, 32'd0, 32'd3, 40'd0, 40'd7, 64'd0, 1'b1});
    // alternating bit patterns on price and amount
    add_row(64'd1000, 32'h8000_0000, 24'h80_0000, BUY, KEEP, 1'b0, NO_CANDLE);
    add_row(64'd1001, 32'h7FFF_FFFF, 24'h7F_FFFF, SELL, KEEP, 1'b0, NO_CANDLE);
    add_row(64'd1002, 32'hAAAA_AAAA, 24'h55_5555, BUY, KEEP, 1'b0, NO_CANDLE);
    add_row(64'd1003, 32'h5555_5555, 24'hAA_AAAA, SELL, FLUSH, 1'b0, NO_CANDLE);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 32'd1, 24'd1, BUY, FLUSH, 1'b1,
            {32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 40'd1, 40'd0,
             64'hAAAA_AAAA_AAAA_AAAA, 1'b1});
    add_row(64'h5555_5555_5555_5555, 32'h1234_5678, 24'h10, SELL, FLUSH, 1'b1,
            {32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
             32'd0, 32'h1234_5678, 40'd0, 40'h10, 64'h5555_5555_5555_5555, 1'b1});

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    idle_pct = 30;
    foreach (directed_rows[i])
      offer_trade(directed_rows[i].trd, directed_rows[i].typed, directed_rows[i].want);

    // shortest nonzero window: any timestamp change closes a candle; most steps keep the timestamp
    settle_then_write(WIN_W'(1));
    ts_now = '0;
    run_random(70, 1'b0);

    // zero window: every trade after the first of a candle starts anew; the
    // receiver holds off for a long stretch while trades keep coming
    settle_then_write('0);
    idle_pct = 25;
    hold_requests++;
    run_random(70, 1'b0);

    // widest window, one long candle whose buy notional saturates; no idling
    settle_then_write(WIN_MAX);
    idle_pct = 0;
    run_random(300, 1'b1);

    // mid-size window with heavy idling on both sides
    settle_then_write(WIN_W'($urandom_range(1000, 100000000)));
    idle_pct = 40;
    run_random(90, 1'b0);

    // last stretch: random full-width window, no idling at all
    settle_then_write(WIN_W'(rand64()));
    idle_pct = 0;
    run_random(100, 1'b0);

    push = 1'b0;
    while (candles_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d trades sent, %0d candles checked, %0d failures", trades_sent,
             candles_checked, fail_count);
    $display("windows: reset value, 1, 0, max, mid-size and random; long pop hold-off");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tca_pkg.sv
hw/rtl/tca_front.sv
hw/rtl/tca_queue.sv
hw/rtl/tca_div.sv
hw/rtl/tca_back.sv
hw/rtl/trade_candle_aggregator_top.sv
tb/sv/tb_top.sv
